// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the sphere point checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, held off while reset is low.
`define UPIS_ASSERT(name, clk_s, rst_s, prop) \
  name: assert property (@(posedge clk_s) disable iff (!rst_s) prop) \
    else $error("upis assertion failed");

// Clocked assertion that also runs through reset.
`define UPIS_ASSERT_ALWAYS(name, clk_s, prop) \
  name: assert property (@(posedge clk_s) prop) \
    else $error("upis assertion failed");

`endif

// ===== rtl/upis_pkg.sv =====
// ----------------------------------------------------------------------------
// upis_pkg
// Types, stage map and constants for the uniform point in sphere unit.
// ----------------------------------------------------------------------------
package upis_pkg;

  // Pipeline shape
  localparam int NHOR     = 4;   // Horner steps per trig series
  localparam int SQ_STEPS = 31;  // square root digits
  localparam int CB_STEPS = 20;  // cube root digits

  localparam int ST_A0   = 0;
  localparam int ST_A1   = 1;
  localparam int ST_HOR  = 2;
  localparam int ST_FIN  = ST_HOR + 2 * NHOR - 1;
  localparam int ST_ROOT = ST_FIN + 1;
  localparam int ST_C0   = ST_ROOT + SQ_STEPS;
  localparam int ST_C1   = ST_C0 + 1;
  localparam int ST_OUT  = ST_C1 + 1;
  localparam int NST     = ST_OUT + 1;

  localparam logic [30:0] ONE_Q30    = 31'h4000_0000;
  localparam logic [32:0] TWO_PI_Q30 = 33'd6746518852;

  // Exact floor division of a 30-bit value by a constant d:
  // multiply by ceil(2^k / d) with k = 30 + ceil(log2 d), then shift by k.
  localparam logic [30:0] SIN_RCP [NHOR] = '{
    31'(((64'd1 << 37) + 64'd71) / 64'd72),
    31'(((64'd1 << 36) + 64'd41) / 64'd42),
    31'(((64'd1 << 35) + 64'd19) / 64'd20),
    31'(((64'd1 << 33) + 64'd5) / 64'd6)
  };
  localparam int SIN_SH [NHOR] = '{37, 36, 35, 33};

  localparam logic [30:0] COS_RCP [NHOR] = '{
    31'(((64'd1 << 36) + 64'd55) / 64'd56),
    31'(((64'd1 << 35) + 64'd29) / 64'd30),
    31'(((64'd1 << 34) + 64'd11) / 64'd12),
    31'(((64'd1 << 31) + 64'd1) / 64'd2)
  };
  localparam int COS_SH [NHOR] = '{36, 35, 34, 31};

  localparam logic signed [24:0] OUT_MAX = 25'sd8388607;
  localparam logic signed [24:0] OUT_MIN = -25'sd8388608;

  typedef enum logic [1:0] {
    REG_RADIUS   = 2'd0,
    REG_CENTRE_X = 2'd1,
    REG_CENTRE_Y = 2'd2,
    REG_CENTRE_Z = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic        neg_ca;
    logic        neg_sa;
    logic        sel_c;
    logic        cp_neg;
    logic [15:0] cp_mag;
    logic [30:0] m;
    logic [15:0] ur;
  } side_t;

  typedef struct packed {
    side_t       side;
    logic [29:0] x;
    logic [29:0] x2;
    logic [30:0] vs;
    logic [30:0] vc;
  } hor_t;

  typedef struct packed {
    logic        neg_ca;
    logic        neg_sa;
    logic        cp_neg;
    logic [15:0] cp_mag;
    logic [30:0] mag_ca;
    logic [30:0] mag_sa;
    logic [31:0] sq_rad;
    logic [33:0] sq_rem;
    logic [30:0] sq_root;
    logic [17:0] cb_rad;
    logic [41:0] cb_rem;
    logic [19:0] cb_root;
    logic [39:0] cb_sq;
  } root_t;

  typedef struct packed {
    logic        neg_ca;
    logic        neg_sa;
    logic        cp_neg;
    logic [15:0] cp_mag;
    logic [24:0] rq;
    logic [30:0] am;
    logic [30:0] bm;
  } prod_t;

  typedef struct packed {
    logic        neg_x;
    logic        neg_y;
    logic        neg_z;
    logic [16:0] xm;
    logic [16:0] ym;
    logic [16:0] zm;
  } coord_t;

endpackage

// ===== rtl/uniform_point_in_sphere_unit.sv =====
// ----------------------------------------------------------------------------
// uniform_point_in_sphere_unit
// Takes one word of three uniform draws per clock and returns one point spread
// uniformly through a sphere of programmable radius and centre. Throughput is
// one word per cycle while out_ready is high. The pipe is 44 register stages:
// ten stages of azimuth fold and sine/cosine series, the 31-stage square root
// digit chain for the polar sine (which carries the cube root alongside), two
// product stages and the output register. Stalled stages close up over
// bubbles, so a new word is taken while a result waits as long as any stage is
// empty. Registers: radius at 0x0 (unsigned Q8), centre x/y/z at 0x4, 0x8,
// 0xC (signed Q8); write them only while the unit is idle.
// ----------------------------------------------------------------------------
module uniform_point_in_sphere_unit import upis_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [15:0]        in_u_azimuth,
  input  logic [15:0]        in_u_polar,
  input  logic [15:0]        in_u_radial,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [23:0] out_point_x,
  output logic signed [23:0] out_point_y,
  output logic signed [23:0] out_point_z,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [15:0]        radius_r;
  logic signed [23:0] centre_x_r;
  logic signed [23:0] centre_y_r;
  logic signed [23:0] centre_z_r;
  logic               cfg_wr;
  reg_idx_t           cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r   <= 16'd256;
      centre_x_r <= '0;
      centre_y_r <= '0;
      centre_z_r <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_RADIUS:   radius_r   <= pwdata[15:0];
        REG_CENTRE_X: centre_x_r <= pwdata[23:0];
        REG_CENTRE_Y: centre_y_r <= pwdata[23:0];
        REG_CENTRE_Z: centre_z_r <= pwdata[23:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_RADIUS:   prdata = {16'd0, radius_r};
      REG_CENTRE_X: prdata = {8'd0, centre_x_r};
      REG_CENTRE_Y: prdata = {8'd0, centre_y_r};
      REG_CENTRE_Z: prdata = {8'd0, centre_z_r};
    endcase
  end

  // --------------------------------------------------------------------------
  // Stage flow control: a stage loads when it is empty or its successor loads
  // --------------------------------------------------------------------------
  logic [NST-1:0] vld_r;
  logic [NST-1:0] vld_nxt;
  logic [NST-1:0] en;

  always_comb begin
    en[NST-1] = !vld_r[NST-1] || out_ready;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  always_comb begin
    vld_nxt = vld_r;
    if (en[0]) vld_nxt[0] = in_valid;
    for (int k = 1; k < NST; k++) begin
      if (en[k]) vld_nxt[k] = vld_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld_r[ST_OUT];

  // --------------------------------------------------------------------------
  // A0: quadrant fold, angle scaling, polar cosine and 1 - c^2
  // --------------------------------------------------------------------------
  side_t       a0_side_r;
  side_t       a0_side_nxt;
  logic [29:0] a0_x_r;
  logic [29:0] a0_x_nxt;
  logic [1:0]  quad;
  logic [13:0] rs;
  logic        swp;
  logic [13:0] rsp;
  logic [46:0] ang_p;
  logic [31:0] cpsq;

  always_comb begin
    quad  = in_u_azimuth[15:14];
    rs    = in_u_azimuth[13:0];
    swp   = rs > 14'd8192;
    // past the octant, use the co-angle and swap sine and cosine
    rsp   = swp ? 14'(15'd16384 - {1'b0, rs}) : rs;
    ang_p = 47'(rsp) * 47'(TWO_PI_Q30);
    a0_x_nxt = ang_p[45:16];

    a0_side_nxt.neg_ca = (quad == 2'd0) || (quad == 2'd3);
    a0_side_nxt.neg_sa = ~quad[1];
    a0_side_nxt.sel_c  = ~quad[0] ^ swp;
    a0_side_nxt.cp_neg = ~in_u_polar[15];
    a0_side_nxt.cp_mag = in_u_polar[15] ? {1'b0, in_u_polar[14:0]}
                                        : 16'h8000 - in_u_polar;
    cpsq = 32'(a0_side_nxt.cp_mag) * 32'(a0_side_nxt.cp_mag);
    a0_side_nxt.m  = 31'(32'h4000_0000 - cpsq);
    a0_side_nxt.ur = in_u_radial;
  end

  always_ff @(posedge clk) begin
    if (en[ST_A0]) begin
      a0_side_r <= a0_side_nxt;
      a0_x_r    <= a0_x_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // A1: square of the angle
  // --------------------------------------------------------------------------
  hor_t        a1_r;
  hor_t        a1_nxt;
  logic [59:0] x2_p;

  always_comb begin
    x2_p        = 60'(a0_x_r) * 60'(a0_x_r);
    a1_nxt.side = a0_side_r;
    a1_nxt.x    = a0_x_r;
    a1_nxt.x2   = x2_p[59:30];
    a1_nxt.vs   = {1'b0, x2_p[59:30]};
    a1_nxt.vc   = {1'b0, x2_p[59:30]};
  end

  always_ff @(posedge clk) begin
    if (en[ST_A1]) a1_r <= a1_nxt;
  end

  // --------------------------------------------------------------------------
  // Horner series: divide stage, then multiply stage, for sine and cosine
  // --------------------------------------------------------------------------
  hor_t dq_r [NHOR];
  hor_t mq_r [NHOR-1];

  for (genvar j = 0; j < NHOR; j++) begin : g_hor
    hor_t        din;
    hor_t        dq_nxt;
    logic [60:0] qs_p;
    logic [60:0] qc_p;

    if (j == 0) begin : g_first
      assign din = a1_r;
    end else begin : g_next
      assign din = mq_r[j-1];
    end

    always_comb begin
      qs_p          = 61'(din.vs[29:0]) * 61'(SIN_RCP[j]);
      qc_p          = 61'(din.vc[29:0]) * 61'(COS_RCP[j]);
      dq_nxt        = din;
      dq_nxt.vs     = ONE_Q30 - 31'(qs_p >> SIN_SH[j]);
      dq_nxt.vc     = ONE_Q30 - 31'(qc_p >> COS_SH[j]);
    end

    always_ff @(posedge clk) begin
      if (en[ST_HOR+2*j]) dq_r[j] <= dq_nxt;
    end

    if (j < NHOR - 1) begin : g_mul
      hor_t        mq_nxt;
      logic [60:0] ps_p;
      logic [60:0] pc_p;

      always_comb begin
        ps_p      = 61'(dq_r[j].x2) * 61'(dq_r[j].vs);
        pc_p      = 61'(dq_r[j].x2) * 61'(dq_r[j].vc);
        mq_nxt    = dq_r[j];
        mq_nxt.vs = {1'b0, ps_p[59:30]};
        mq_nxt.vc = {1'b0, pc_p[59:30]};
      end

      always_ff @(posedge clk) begin
        if (en[ST_HOR+2*j+1]) mq_r[j] <= mq_nxt;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Finish sine, place into quadrant, seed both root units
  // --------------------------------------------------------------------------
  root_t       fin_r;
  root_t       fin_nxt;
  logic [60:0] s_p;
  logic [30:0] s0;
  logic [30:0] c0;

  always_comb begin
    s_p = 61'(dq_r[NHOR-1].x) * 61'(dq_r[NHOR-1].vs);
    s0  = {1'b0, s_p[59:30]};
    c0  = dq_r[NHOR-1].vc;
    fin_nxt.neg_ca  = dq_r[NHOR-1].side.neg_ca;
    fin_nxt.neg_sa  = dq_r[NHOR-1].side.neg_sa;
    fin_nxt.cp_neg  = dq_r[NHOR-1].side.cp_neg;
    fin_nxt.cp_mag  = dq_r[NHOR-1].side.cp_mag;
    fin_nxt.mag_ca  = dq_r[NHOR-1].side.sel_c ? c0 : s0;
    fin_nxt.mag_sa  = dq_r[NHOR-1].side.sel_c ? s0 : c0;
    fin_nxt.sq_rad  = {1'b0, dq_r[NHOR-1].side.m};
    fin_nxt.sq_rem  = '0;
    fin_nxt.sq_root = '0;
    fin_nxt.cb_rad  = {dq_r[NHOR-1].side.ur, 2'b00};
    fin_nxt.cb_rem  = '0;
    fin_nxt.cb_root = '0;
    fin_nxt.cb_sq   = '0;
  end

  always_ff @(posedge clk) begin
    if (en[ST_FIN]) fin_r <= fin_nxt;
  end

  // --------------------------------------------------------------------------
  // Root chain: one square root digit per stage, one cube root digit per
  // stage over the first stages (cube root tracks y^2 to avoid multiplies)
  // --------------------------------------------------------------------------
  root_t rt_r [SQ_STEPS];

  for (genvar i = 0; i < SQ_STEPS; i++) begin : g_root
    root_t       rin;
    root_t       rt_nxt;
    logic [35:0] sq_tmp;
    logic [35:0] sq_try;
    logic        sq_ge;
    logic [44:0] cb_tmp;
    logic [44:0] cb_try;
    logic        cb_ge;

    if (i == 0) begin : g_first
      assign rin = fin_r;
    end else begin : g_next
      assign rin = rt_r[i-1];
    end

    always_comb begin
      rt_nxt = rin;

      sq_tmp = {rin.sq_rem, rin.sq_rad[31:30]};
      sq_try = {3'b000, rin.sq_root, 2'b01};
      sq_ge  = sq_tmp >= sq_try;
      rt_nxt.sq_rem  = sq_ge ? 34'(sq_tmp - sq_try) : 34'(sq_tmp);
      rt_nxt.sq_root = {rin.sq_root[29:0], sq_ge};
      rt_nxt.sq_rad  = {rin.sq_rad[29:0], 2'b00};

      // (2y+1)^3 - (2y)^3 = 12y^2 + 6y + 1
      cb_tmp = {rin.cb_rem, rin.cb_rad[17:15]};
      cb_try = 45'({rin.cb_sq, 3'b000}) + 45'({rin.cb_sq, 2'b00})
             + 45'({rin.cb_root, 2'b00}) + 45'({rin.cb_root, 1'b0}) + 45'd1;
      cb_ge  = cb_tmp >= cb_try;
      if (i < CB_STEPS) begin
        rt_nxt.cb_rem  = cb_ge ? 42'(cb_tmp - cb_try) : 42'(cb_tmp);
        rt_nxt.cb_root = {rin.cb_root[18:0], cb_ge};
        rt_nxt.cb_sq   = 40'({rin.cb_sq, 2'b00}
                       + (cb_ge ? 42'({rin.cb_root, 2'b01}) : 42'd0));
        rt_nxt.cb_rad  = {rin.cb_rad[14:0], 3'b000};
      end
    end

    always_ff @(posedge clk) begin
      if (en[ST_ROOT+i]) rt_r[i] <= rt_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // C0: scaled radius and horizontal direction
  // --------------------------------------------------------------------------
  prod_t       c0_r;
  prod_t       c0_nxt;
  logic [36:0] rq_p;
  logic [62:0] am_p;
  logic [62:0] bm_p;

  always_comb begin
    rq_p = 37'(radius_r) * 37'(rt_r[SQ_STEPS-1].cb_root) + 37'd2048;
    am_p = 63'(rt_r[SQ_STEPS-1].mag_ca) * 63'(rt_r[SQ_STEPS-1].sq_root)
         + (63'd1 << 29);
    bm_p = 63'(rt_r[SQ_STEPS-1].mag_sa) * 63'(rt_r[SQ_STEPS-1].sq_root)
         + (63'd1 << 29);
    c0_nxt.neg_ca = rt_r[SQ_STEPS-1].neg_ca;
    c0_nxt.neg_sa = rt_r[SQ_STEPS-1].neg_sa;
    c0_nxt.cp_neg = rt_r[SQ_STEPS-1].cp_neg;
    c0_nxt.cp_mag = rt_r[SQ_STEPS-1].cp_mag;
    c0_nxt.rq     = rq_p[36:12];
    c0_nxt.am     = am_p[60:30];
    c0_nxt.bm     = bm_p[60:30];
  end

  always_ff @(posedge clk) begin
    if (en[ST_C0]) c0_r <= c0_nxt;
  end

  // --------------------------------------------------------------------------
  // C1: coordinate magnitudes, rounded half away from zero
  // --------------------------------------------------------------------------
  coord_t      c1_r;
  coord_t      c1_nxt;
  logic [56:0] xm_p;
  logic [56:0] ym_p;
  logic [41:0] zm_p;

  always_comb begin
    xm_p = 57'(c0_r.rq) * 57'(c0_r.am) + (57'd1 << 37);
    ym_p = 57'(c0_r.rq) * 57'(c0_r.bm) + (57'd1 << 37);
    zm_p = 42'(c0_r.rq) * 42'(c0_r.cp_mag) + (42'd1 << 22);
    c1_nxt.neg_x = c0_r.neg_ca;
    c1_nxt.neg_y = c0_r.neg_sa;
    c1_nxt.neg_z = c0_r.cp_neg;
    c1_nxt.xm    = 17'(xm_p >> 38);
    c1_nxt.ym    = 17'(ym_p >> 38);
    c1_nxt.zm    = 17'(zm_p >> 23);
  end

  always_ff @(posedge clk) begin
    if (en[ST_C1]) c1_r <= c1_nxt;
  end

  // --------------------------------------------------------------------------
  // Output: apply sign, add centre, clamp
  // --------------------------------------------------------------------------
  function automatic logic signed [23:0] add_sat(input logic neg,
                                                 input logic [16:0] mag,
                                                 input logic signed [23:0] ctr);
    logic signed [24:0] v;
    logic signed [24:0] sum;
    v   = neg ? -$signed({8'd0, mag}) : $signed({8'd0, mag});
    sum = v + $signed({ctr[23], ctr});
    if (sum > OUT_MAX) sum = OUT_MAX;
    if (sum < OUT_MIN) sum = OUT_MIN;
    return sum[23:0];
  endfunction

  logic signed [23:0] out_x_r;
  logic signed [23:0] out_y_r;
  logic signed [23:0] out_z_r;

  always_ff @(posedge clk) begin
    if (en[ST_OUT]) begin
      out_x_r <= add_sat(c1_r.neg_x, c1_r.xm, centre_x_r);
      out_y_r <= add_sat(c1_r.neg_y, c1_r.ym, centre_y_r);
      out_z_r <= add_sat(c1_r.neg_z, c1_r.zm, centre_z_r);
    end
  end

  assign out_point_x = out_x_r;
  assign out_point_y = out_y_r;
  assign out_point_z = out_z_r;

endmodule

// ===== rtl/upis_checker.sv =====
// ----------------------------------------------------------------------------
// upis_checker
// Port-level checks for the uniform point in sphere unit, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module upis_checker import upis_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [23:0] out_point_x,
  input logic signed [23:0] out_point_y,
  input logic signed [23:0] out_point_z,
  input logic               psel,
  input logic               penable,
  input logic               pwrite,
  input logic [3:0]         paddr,
  input logic [31:0]        pwdata,
  input logic [31:0]        prdata
);

  // hold a stalled result
  `UPIS_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid)
  `UPIS_ASSERT(a_out_stable, clk, rst_n, out_valid && !out_ready |=> $stable(out_point_x) && $stable(out_point_y) && $stable(out_point_z))

  // a free output stage lets the whole pipe advance
  `UPIS_ASSERT(a_in_free, clk, rst_n, (!out_valid || out_ready) |-> in_ready)

  // reset drops any pending result
  `UPIS_ASSERT_ALWAYS(a_rst_clear, clk, !rst_n |=> !out_valid)

  // radius write reads back on the next cycle
  `UPIS_ASSERT(a_radius_rb, clk, rst_n, psel && penable && pwrite && (paddr[3:2] == REG_RADIUS) ##1 (paddr[3:2] == REG_RADIUS) |-> prdata[15:0] == $past(pwdata[15:0]))

endmodule

bind uniform_point_in_sphere_unit upis_checker u_upis_checker (.*);

// ===== verif/uniform_point_in_sphere_unit_chk.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// uniform_point_in_sphere_unit_chk
// Watches the draw and point channels and the register port of the sphere
// point unit, works out each point from the draws and the current radius and
// centre, and compares the points that leave the unit in order.
// ----------------------------------------------------------------------------
module uniform_point_in_sphere_unit_chk import upis_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [15:0]        in_u_azimuth,
  input  logic [15:0]        in_u_polar,
  input  logic [15:0]        in_u_radial,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [23:0] out_point_x,
  input  logic signed [23:0] out_point_y,
  input  logic signed [23:0] out_point_z,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  output int                 errors,
  output int                 points_pending,
  output int                 points_seen
);

  localparam logic [63:0] Q30 = 64'd1 << 30;
  localparam logic [63:0] AZ_SCALE = 64'd6746518852;

  typedef struct packed {
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic signed [23:0] z;
  } point_t;

  logic [15:0]        radius_q8;
  logic signed [23:0] ctr_x, ctr_y, ctr_z;
  point_t             point_q[$];

  function automatic void series_sin_cos(input logic [63:0] ang,
                                         output logic [63:0] s,
                                         output logic [63:0] c);
    logic [63:0] a2, t;
    a2 = (ang * ang) >> 30;
    t = Q30 - a2 / 72;
    t = Q30 - ((a2 * t) >> 30) / 42;
    t = Q30 - ((a2 * t) >> 30) / 20;
    t = Q30 - ((a2 * t) >> 30) / 6;
    s = (ang * t) >> 30;
    t = Q30 - a2 / 56;
    t = Q30 - ((a2 * t) >> 30) / 30;
    t = Q30 - ((a2 * t) >> 30) / 12;
    c = Q30 - ((a2 * t) >> 30) / 2;
  endfunction

  function automatic logic [63:0] sqrt_floor(input logic [63:0] n);
    logic [63:0] res, bt;
    res = 0;
    bt = 64'd1 << 62;
    while (bt > n) bt = bt >> 2;
    while (bt != 0) begin
      if (n >= res + bt) begin
        n = n - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] cbrt_floor(input logic [63:0] n);
    logic [63:0] y, t;
    y = 0;
    for (int b = 19; b >= 0; b--) begin
      t = y | (64'd1 << b);
      if (t * t * t <= n) y = t;
    end
    return y;
  endfunction

  function automatic logic [63:0] magnitude(input longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  // Sign and magnitude product, rounded half away from zero.
  function automatic longint mul_round(input longint a, input longint b, input int sh);
    logic [63:0] m;
    m = (magnitude(a) * magnitude(b) + (64'd1 << (sh - 1))) >> sh;
    return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
  endfunction

  function automatic logic signed [23:0] clamp24(input longint v);
    if (v > 8388607) return 24'sh7FFFFF;
    if (v < -8388608) return 24'sh800000;
    return v[23:0];
  endfunction

  function automatic point_t sphere_point(input logic [15:0] ua, input logic [15:0] up,
                                          input logic [15:0] ur);
    logic [63:0] rest, s, c, sinp, cb;
    longint      cq, sq, caz, saz, cp, a, b, rq;
    point_t      p;
    rest = 64'(ua[13:0]);
    if (rest > 8192) series_sin_cos(((16384 - rest) * AZ_SCALE) >> 16, c, s);
    else series_sin_cos((rest * AZ_SCALE) >> 16, s, c);
    cq = longint'(c);
    sq = longint'(s);
    case (ua[15:14])
      2'd0: begin caz = cq;  saz = sq;  end
      2'd1: begin caz = -sq; saz = cq;  end
      2'd2: begin caz = -cq; saz = -sq; end
      default: begin caz = sq; saz = -cq; end
    endcase
    // the -pi azimuth offset flips both
    caz = -caz;
    saz = -saz;
    cp = longint'(up) - 32768;
    sinp = sqrt_floor((Q30 - 64'(cp * cp)) << 30);
    cb = cbrt_floor(64'(ur) << 44);
    rq = longint'((64'(radius_q8) * cb + 64'd2048) >> 12);
    a = mul_round(caz, longint'(sinp), 30);
    b = mul_round(saz, longint'(sinp), 30);
    p.x = clamp24(mul_round(rq, a, 38) + longint'(ctr_x));
    p.y = clamp24(mul_round(rq, b, 38) + longint'(ctr_y));
    p.z = clamp24(mul_round(rq, cp, 23) + longint'(ctr_z));
    return p;
  endfunction

  task automatic report_mismatch(input string what, input logic signed [23:0] got,
                                 input logic signed [23:0] want);
    $display("%0t: %s mismatch: got %0d, want %0d", $time, what, got, want);
    errors++;
  endtask

  assign points_pending = point_q.size();

  initial begin
    errors = 0;
    points_seen = 0;
  end

  always @(posedge clk) begin
    point_t want;
    if (!rst_n) begin
      radius_q8 <= 16'd256;
      ctr_x <= '0;
      ctr_y <= '0;
      ctr_z <= '0;
      point_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[3:2]))
          REG_RADIUS:   radius_q8 <= pwdata[15:0];
          REG_CENTRE_X: ctr_x <= pwdata[23:0];
          REG_CENTRE_Y: ctr_y <= pwdata[23:0];
          REG_CENTRE_Z: ctr_z <= pwdata[23:0];
        endcase
      end
      if (in_valid && in_ready)
        point_q.push_back(sphere_point(in_u_azimuth, in_u_polar, in_u_radial));
      if (out_valid && out_ready) begin
        points_seen++;
        if (point_q.size() == 0) begin
          $display("%0t: point word with nothing outstanding", $time);
          errors++;
        end else begin
          want = point_q.pop_front();
          if (out_point_x !== want.x) report_mismatch("point_x", out_point_x, want.x);
          if (out_point_y !== want.y) report_mismatch("point_y", out_point_y, want.y);
          if (out_point_z !== want.z) report_mismatch("point_z", out_point_z, want.z);
        end
      end
    end
  end

endmodule

// ===== verif/uniform_point_in_sphere_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// uniform_point_in_sphere_unit_tb
// Drives draw words through the sphere point unit under several radius and
// centre settings, with random gaps and output stalls; the checker beside the
// unit predicts and compares every point.
// ----------------------------------------------------------------------------
module uniform_point_in_sphere_unit_tb;
  import upis_pkg::*;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [15:0]        in_u_azimuth = '0;
  logic [15:0]        in_u_polar = '0;
  logic [15:0]        in_u_radial = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [23:0] out_point_x, out_point_y, out_point_z;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [3:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  int                 errors, points_pending, points_seen;
  bit                 steady = 1'b0;
  int                 stall_left = 0;
  int                 settings_run = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  uniform_point_in_sphere_unit i_dut (.*);

  uniform_point_in_sphere_unit_chk i_chk (.*);

  initial begin
    #5ms;
    $display("uniform_point_in_sphere_unit_tb: done, errors");
    $finish;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(99);
    if (steady || r < 65) return 0;
    if (r < 94) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // Result side: hold ready low for random stretches.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else begin
      stall_left <= gap_len();
      out_ready <= 1'b1;
    end
  end

  task automatic reg_write(input reg_idx_t idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_draws(input logic [15:0] ua, input logic [15:0] up,
                            input logic [15:0] ur);
    bit taken;
    int gap;
    in_valid <= 1'b1;
    in_u_azimuth <= ua;
    in_u_polar <= up;
    in_u_radial <= ur;
    do begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end while (!taken);
    gap = gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold off until every point has come out and the pipe has drained.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (points_pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic configure(input logic [15:0] rad, input logic [23:0] cx,
                           input logic [23:0] cy, input logic [23:0] cz);
    reg_write(REG_RADIUS, {16'd0, rad});
    reg_write(REG_CENTRE_X, {8'd0, cx});
    reg_write(REG_CENTRE_Y, {8'd0, cy});
    reg_write(REG_CENTRE_Z, {8'd0, cz});
    settings_run++;
  endtask

  function automatic logic [15:0] draw16();
    case ($urandom_range(9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return {2'($urandom_range(3)), 14'h2000} + 16'($urandom_range(2)) - 16'd1;
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  task automatic random_draws(input int n);
    for (int i = 0; i < n; i++) begin
      steady = (i % 100) >= 80;
      send_draws(draw16(), draw16(), draw16());
    end
    steady = 1'b0;
  endtask

  initial begin
    logic [15:0] az_dir [8] = '{16'h0000, 16'h2000, 16'h2001, 16'h4000,
                                16'h8000, 16'hC000, 16'hDFFF, 16'hFFFF};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: unit sphere at the origin
    foreach (az_dir[i]) send_draws(az_dir[i], 16'h8000 + 16'(i * 4096), 16'hFFFF);
    send_draws(16'h1234, 16'h0000, 16'hFFFF);
    send_draws(16'h5678, 16'hFFFF, 16'hFFFF);
    send_draws(16'h9ABC, 16'h8000, 16'h0000);
    send_draws(16'hFFFF, 16'h0001, 16'h0001);
    send_draws(16'hAAAA, 16'h5555, 16'h5555);
    send_draws(16'h5555, 16'hAAAA, 16'hAAAA);
    random_draws(320);
    drain();

    configure(16'hFFFF, 24'h7FFFFF, 24'h800000, 24'h7FFF00);
    send_draws(16'h0000, 16'hFFFF, 16'hFFFF);
    send_draws(16'h8000, 16'h0000, 16'hFFFF);
    send_draws(16'h4000, 16'h8000, 16'hFFFF);
    random_draws(320);
    drain();

    configure(16'h0000, 24'h800000, 24'h7FFFFF, 24'h000000);
    random_draws(200);
    drain();

    configure(16'hFFFF, 24'h000000, 24'h000000, 24'h800000);
    random_draws(320);
    drain();

    for (int k = 0; k < 3; k++) begin
      configure(16'($urandom_range(65535)), 24'($urandom), 24'($urandom), 24'($urandom));
      random_draws(260);
      drain();
    end

    configure(16'd1, 24'h000001, 24'hFFFFFF, 24'h000100);
    random_draws(60);
    drain();

    $display("covered %0d points over %0d radius/centre settings, incl. saturation",
             points_seen, settings_run + 1);
    $display("and zero radius, with random input gaps and output stalls");
    if (errors == 0) begin
      $display("uniform_point_in_sphere_unit_tb: done, clean");
    end else begin
      $display("uniform_point_in_sphere_unit_tb: done, errors");
    end
    $finish;
  end

endmodule
